// ----- design/ffsa_pkg.sv -----
// Shared types, constants and helpers for the first-fit segment allocator.
// Used by ffsa_front, ffsa_engine and first_fit_segment_allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

  localparam int MAX_SEGMENTS   = 64;
  localparam int SEG_BITS       = $clog2(MAX_SEGMENTS);
  localparam int HEADER_BYTES   = 32;
  localparam int ALIGN_BYTES    = 16;
  localparam int POOL_ADDR_BITS = 20;

  localparam int SIZE_W  = 21;
  localparam int WANT_W  = SIZE_W + 1;
  localparam int OFF_W   = 20;
  localparam int LEN_W   = 21;
  localparam int COUNT_W = 16;

  localparam logic [SIZE_W-1:0]  POOL_RESET = SIZE_W'(65536);
  localparam logic [SIZE_W-1:0]  POOL_LIMIT = SIZE_W'(64'd1 << POOL_ADDR_BITS);
  localparam logic [SIZE_W-1:0]  MAX_TOTAL  = '1;
  localparam logic [COUNT_W-1:0] MAX_COUNT  = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_ZERO
  } kind_t;

  typedef enum logic [3:0] {
    E_INIT,
    E_IDLE,
    E_HCHK,
    E_AWALK,
    E_SPLIT,
    E_COMMIT,
    E_FWALK,
    E_FPREV,
    E_FNCHK,
    E_FNEXT,
    E_FFIN,
    E_RESULT
  } eng_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [SIZE_W-1:0]  size;
    logic [WANT_W-1:0]  want;
    logic [OFF_W-1:0]   offset;
  } item_t;

  typedef struct packed {
    logic [OFF_W-1:0]    start;
    logic [LEN_W-1:0]    len;
    logic [SEG_BITS-1:0] link;
    logic                has_next;
  } seg_entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] live_count;
    logic [SIZE_W-1:0]  peak_requested;
    logic [SIZE_W-1:0]  requested_bytes;
    logic [SIZE_W-1:0]  reserved_bytes;
    logic [OFF_W-1:0]   payload_offset;
    status_t            status;
  } result_t;

  // Rounds a byte count up to the next multiple of the alignment.
  function automatic logic [WANT_W-1:0] round_up(input logic [SIZE_W-1:0] s);
    logic [WANT_W:0] t;
    t = {2'b00, s} + (WANT_W+1)'(ALIGN_BYTES - 1);
    round_up = WANT_W'((t / ALIGN_BYTES) * ALIGN_BYTES);
  endfunction

endpackage
`default_nettype wire

// ----- design/ffsa_front.sv -----
// Front end: accepts request words, classifies them and queues them.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_front
  import ffsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire logic [47:0] s_tdata,  // size_bytes[20:0], block_offset[40:21], zeros
  input  wire logic  s_tuser,        // operation
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);

  item_t              fifo [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  item_t              cls;
  logic               push;
  logic               pop;

  always_comb begin
    cls.size   = s_tdata[20:0];
    cls.offset = s_tdata[40:21];
    cls.want   = round_up(s_tdata[20:0]);
    if (s_tdata[20:0] == '0) begin
      cls.kind = K_ZERO;
    end else if (s_tuser == OP_FREE) begin
      cls.kind = K_FREE;
    end else begin
      cls.kind = K_ALLOC;
    end
  end

  assign s_tready = (count != (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = fifo[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/ffsa_engine.sv -----
// Back end: walks the segment table, splits and coalesces, keeps the totals.
// Depends on ffsa_pkg; holds the segment table memory.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_engine
  import ffsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic [SIZE_W-1:0]  cfg_wdata,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire item_t              q_item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res
);

  seg_entry_t mem [MAX_SEGMENTS];
  seg_entry_t rdata;
  logic [SEG_BITS-1:0] raddr;
  logic                we;
  logic [SEG_BITS-1:0] waddr;
  seg_entry_t          wdata;

  eng_state_t state, state_next;
  logic [SIZE_W-1:0] pool_size;
  logic [MAX_SEGMENTS-1:0] live, live_next;
  logic [MAX_SEGMENTS-1:0] used, used_next;
  logic [SEG_BITS-1:0] hint, hint_next;
  logic hint_valid, hint_valid_next;
  item_t item, item_next;
  logic [SEG_BITS-1:0] cur, cur_next;
  logic [SEG_BITS-1:0] prev, prev_next;
  logic has_prev, has_prev_next;
  logic [SEG_BITS-1:0] cnt, cnt_next;
  seg_entry_t wk, wk_next;
  status_t status, status_next;
  logic [OFF_W-1:0] payload, payload_next;
  logic [SIZE_W-1:0] reserved, reserved_next;
  logic [SIZE_W-1:0] requested, requested_next;
  logic [SIZE_W-1:0] peak, peak_next;
  logic [COUNT_W-1:0] count, count_next;

  logic                free_found;
  logic [SEG_BITS-1:0] free_idx;
  logic [WANT_W:0]     res_sum;
  logic [WANT_W-1:0]   req_sum;

  // Lowest table entry not in use, taken by a split.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = SEG_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign res_sum = {2'b00, reserved} + {1'b0, item.want};
  assign req_sum = {1'b0, requested} + {1'b0, item.size};

  always_comb begin
    state_next      = state;
    live_next       = live;
    used_next       = used;
    hint_next       = hint;
    hint_valid_next = hint_valid;
    item_next       = item;
    cur_next        = cur;
    prev_next       = prev;
    has_prev_next   = has_prev;
    cnt_next        = cnt;
    wk_next         = wk;
    status_next     = status;
    payload_next    = payload;
    reserved_next   = reserved;
    requested_next  = requested;
    peak_next       = peak;
    count_next      = count;
    raddr           = cur;
    we              = 1'b0;
    waddr           = cur;
    wdata           = wk;
    q_ready         = 1'b0;
    res_valid       = 1'b0;

    case (state)
      E_INIT: begin
        we             = 1'b1;
        waddr          = '0;
        wdata.start    = '0;
        wdata.len      = (pool_size > POOL_LIMIT) ? POOL_LIMIT : pool_size;
        wdata.link     = '0;
        wdata.has_next = 1'b0;
        live_next      = MAX_SEGMENTS'(1);
        used_next      = '0;
        hint_next      = '0;
        hint_valid_next = 1'b1;
        reserved_next  = '0;
        requested_next = '0;
        peak_next      = '0;
        count_next     = '0;
        state_next     = E_IDLE;
      end

      E_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_next    = q_item;
          payload_next = '0;
          cnt_next     = '0;
          case (q_item.kind)
            K_ALLOC: begin
              raddr      = hint;
              state_next = E_HCHK;
            end
            K_FREE: begin
              raddr         = '0;
              cur_next      = '0;
              has_prev_next = 1'b0;
              state_next    = E_FWALK;
            end
            default: begin
              status_next = ST_ZERO;
              state_next  = E_RESULT;
            end
          endcase
        end
      end

      E_HCHK: begin
        if (hint_valid && live[hint] && !used[hint]
            && item.want <= {1'b0, rdata.len}) begin
          cur_next        = hint;
          raddr           = hint;
          hint_valid_next = 1'b0;
        end else begin
          cur_next = '0;
          raddr    = '0;
        end
        state_next = E_AWALK;
      end

      E_AWALK: begin
        if (!used[cur] && item.want <= {1'b0, rdata.len}) begin
          wk_next    = rdata;
          state_next = E_SPLIT;
        end else if (!rdata.has_next || cnt == SEG_BITS'(MAX_SEGMENTS - 1)) begin
          status_next = ST_NOFIT;
          state_next  = E_RESULT;
        end else begin
          cur_next = rdata.link;
          raddr    = rdata.link;
          cnt_next = cnt + 1'b1;
        end
      end

      E_SPLIT: begin
        // Split only when the remainder is larger than one header and a table entry is free.
        if (({1'b0, item.want} + (WANT_W+1)'(HEADER_BYTES)) < (WANT_W+1)'(wk.len)
            && free_found) begin
          we             = 1'b1;
          waddr          = free_idx;
          wdata.start    = wk.start + OFF_W'(HEADER_BYTES) + item.want[OFF_W-1:0];
          wdata.len      = LEN_W'((WANT_W+1)'(wk.len) - (WANT_W+1)'(HEADER_BYTES)
                                  - {1'b0, item.want});
          wdata.link     = wk.link;
          wdata.has_next = wk.has_next;
          live_next[free_idx] = 1'b1;
          used_next[free_idx] = 1'b0;
          wk_next.link     = free_idx;
          wk_next.has_next = 1'b1;
          wk_next.len      = item.want[LEN_W-1:0];
        end
        state_next = E_COMMIT;
      end

      E_COMMIT: begin
        we             = 1'b1;
        waddr          = cur;
        wdata          = wk;
        used_next[cur] = 1'b1;
        if (wk.has_next && !used[wk.link]) begin
          hint_next       = wk.link;
          hint_valid_next = 1'b1;
        end
        reserved_next  = (res_sum > (WANT_W+1)'(MAX_TOTAL)) ? MAX_TOTAL
                                                          : res_sum[SIZE_W-1:0];
        requested_next = (req_sum > WANT_W'(MAX_TOTAL)) ? MAX_TOTAL
                                                         : req_sum[SIZE_W-1:0];
        if (peak < requested_next) peak_next = requested_next;
        if (count != MAX_COUNT) count_next = count + 1'b1;
        payload_next = wk.start + OFF_W'(HEADER_BYTES);
        status_next  = ST_OK;
        state_next   = E_RESULT;
      end

      E_FWALK: begin
        if (used[cur] && (rdata.start + OFF_W'(HEADER_BYTES)) == item.offset) begin
          wk_next        = rdata;
          used_next[cur] = 1'b0;
          if (has_prev && !used[prev]) begin
            raddr      = prev;
            state_next = E_FPREV;
          end else begin
            state_next = E_FNCHK;
          end
        end else if (!rdata.has_next || cnt == SEG_BITS'(MAX_SEGMENTS - 1)) begin
          status_next = ST_BADFREE;
          state_next  = E_RESULT;
        end else begin
          prev_next     = cur;
          has_prev_next = 1'b1;
          cur_next      = rdata.link;
          raddr         = rdata.link;
          cnt_next      = cnt + 1'b1;
        end
      end

      E_FPREV: begin
        // The previous segment is free and absorbs the released one.
        wk_next.start    = rdata.start;
        wk_next.len      = LEN_W'((WANT_W)'(rdata.len) + WANT_W'(HEADER_BYTES)
                                  + WANT_W'(wk.len));
        wk_next.link     = wk.link;
        wk_next.has_next = wk.has_next;
        we             = 1'b1;
        waddr          = prev;
        wdata          = wk_next;
        live_next[cur] = 1'b0;
        used_next[cur] = 1'b0;
        cur_next       = prev;
        state_next     = E_FNCHK;
      end

      E_FNCHK: begin
        if (wk.has_next && !used[wk.link]) begin
          raddr      = wk.link;
          state_next = E_FNEXT;
        end else begin
          state_next = E_FFIN;
        end
      end

      E_FNEXT: begin
        wk_next.len      = LEN_W'((WANT_W)'(wk.len) + WANT_W'(HEADER_BYTES)
                                  + WANT_W'(rdata.len));
        wk_next.link     = rdata.link;
        wk_next.has_next = rdata.has_next;
        we                 = 1'b1;
        waddr              = cur;
        wdata              = wk_next;
        live_next[wk.link] = 1'b0;
        used_next[wk.link] = 1'b0;
        state_next         = E_FFIN;
      end

      E_FFIN: begin
        hint_next       = cur;
        hint_valid_next = 1'b1;
        reserved_next   = ({1'b0, reserved} >= item.want)
                          ? SIZE_W'({1'b0, reserved} - item.want) : '0;
        requested_next  = (requested >= item.size) ? requested - item.size : '0;
        if (count != '0) count_next = count - 1'b1;
        status_next = ST_OK;
        state_next  = E_RESULT;
      end

      E_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = E_IDLE;
      end

      default: state_next = E_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= E_INIT;
      pool_size  <= POOL_RESET;
      live       <= '0;
      used       <= '0;
      hint_valid <= 1'b0;
    end else if (cfg_wen) begin
      state     <= E_INIT;
      pool_size <= cfg_wdata;
    end else begin
      state      <= state_next;
      live       <= live_next;
      used       <= used_next;
      hint_valid <= hint_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hint      <= hint_next;
    item      <= item_next;
    cur       <= cur_next;
    prev      <= prev_next;
    has_prev  <= has_prev_next;
    cnt       <= cnt_next;
    wk        <= wk_next;
    status    <= status_next;
    payload   <= payload_next;
    reserved  <= reserved_next;
    requested <= requested_next;
    peak      <= peak_next;
    count     <= count_next;
  end

  always_comb begin
    res.status          = status;
    res.payload_offset  = payload;
    res.reserved_bytes  = reserved;
    res.requested_bytes = requested;
    res.peak_requested  = peak;
    res.live_count      = count;
  end

endmodule
`default_nettype wire

// ----- design/first_fit_segment_allocator.sv -----
// Top level of the first-fit segment allocator: front queue, engine, output register.
// Depends on ffsa_pkg, ffsa_front and ffsa_engine.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_wen            cfg_wdata = pool_size
//   s_*       in         s_tvalid/s_tready  s_tdata, s_tuser
//   m_*       out        m_tvalid/m_tready  m_tdata
//
// An allocate checks the hint entry, then walks the table first-fit, splits and commits;
// a free walks the table to the block, then merges it with free neighbours.
// The single-port segment table read limits each walk to one entry per cycle.
// After reset or a pool_size write, the E_INIT state re-forms the pool before requests run.
// A two-word queue takes requests while the engine works; one result word waits in m_tdata.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [20:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,   // size_bytes[20:0], block_offset[40:21], zeros
  input  wire logic         s_tuser,   // operation
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata    // status[1:0], payload_offset[21:2],
                                       // reserved_bytes[42:22], requested_bytes[63:43],
                                       // peak_requested[84:64], live_count[100:85], zeros
);

  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  ffsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ffsa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {3'b000, res.live_count, res.peak_requested, res.requested_bytes,
                  res.reserved_bytes, res.payload_offset, res.status};
    end
  end

endmodule
`default_nettype wire
